/* src/ber_tlv_stream_parser_defines.svh */
// Assertion macros used by the parser checker
`ifndef BER_TLV_STREAM_PARSER_DEFINES_SVH
`define BER_TLV_STREAM_PARSER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define BTSP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define BTSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/btsp_pkg.sv */
// Types, codes and constants of the BER TLV stream parser
package btsp_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int MAX_RESULTS     = 18;
   localparam int POS_W           = 31;
   localparam int STACK_W         = 2 * POS_W + 1;
   localparam int CNT_W           = 5;
   localparam int DEPTH_W         = 5;

   localparam logic       OP_START   = 1'b0;
   localparam logic       OP_BYTE    = 1'b1;
   localparam logic [7:0] LEN_INDEF  = 8'h80;
   localparam logic [6:0] LEN_MAX_NB = 7'd4;
   localparam int         TAG_CONS_BIT = 5;

   typedef enum logic [1:0] {
      KIND_OPEN  = 2'd0,
      KIND_CLOSE = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_BUFFER = 2'd1,
      ERR_LENGTH = 2'd2,
      ERR_DEPTH  = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_TAG  = 3'd1,
      PH_LEN  = 3'd2,
      PH_LENX = 3'd3,
      PH_SKIP = 3'd4,
      PH_DONE = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_SETTLE = 3'd1,
      S_SRD    = 3'd2,
      S_EOC    = 3'd3,
      S_ERD    = 3'd4
   } state_type;

   typedef struct packed {
      kind_type               kind;
      err_type                err;
      logic [7:0]             tag;
      logic [POS_W-1:0]       hoff;
      logic [POS_W-1:0]       coff;
      logic [POS_W-1:0]       clen;
      logic                   cons;
      logic                   indef;
      logic [DEPTH_W-1:0]     depth;
   } rec_type;

   typedef struct packed {
      logic [POS_W-1:0] parent_end;
      logic [POS_W-1:0] content_start;
      logic             indef;
   } frame_type;

endpackage

/* src/btsp_ram.sv */
// Generic single-write, single-read RAM with registered read data
module btsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ber_tlv_stream_parser.sv */
// Top level of the BER TLV stream parser
// Parses a BER encoding that arrives one byte per beat after a start beat carrying the message
// length, and reports open, close, finished and error records. A byte that yields no record and
// ends no element leaves the parser free to take the next beat, so primitive contents and most
// header bytes stream at one byte per clock. The records of a beat are produced after it is
// accepted, and req_stall stays high until they are out. The steps after the accepting beat:
// - a hand-over of the final record, when the byte yields any record;
// - a check for used-up frames, when the byte ends a constructed or empty header, the contents
//   of an element or an end-of-contents element; this check also reports a finished parse;
// - a stack read and then a pop for each frame closed. The frame stack lives in a synchronous
//   memory of STACK_DEPTH entries with registered read data, so a frame is read before it is
//   popped; an unterminated indefinite frame is reported as an error in place of the pop;
// - an end-of-contents step that finishes the parse at top level and else closes a frame.
// A record that rsp_stall holds back holds the step that produced it. The stack needs no
// clearing pass: only pushed entries are read.
module ber_tlv_stream_parser #(
   parameter int STACK_DEPTH = btsp_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [30:0] req_message_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_error_code,
   output logic [7:0]  rsp_tag,
   output logic [30:0] rsp_header_offset,
   output logic [30:0] rsp_content_offset,
   output logic [30:0] rsp_content_length,
   output logic        rsp_constructed,
   output logic        rsp_indefinite,
   output logic [4:0]  rsp_depth,
   output logic        rsp_last
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int PW   = btsp_pkg::POS_W;

   btsp_pkg::state_type state_ff, state_in;
   btsp_pkg::phase_type phase_ff, phase_in;
   logic [PW-1:0]   bpos_ff, bpos_in;
   logic [PW-1:0]   fend_ff, fend_in;
   logic [7:0]      tag_ff, tag_in;
   logic [PW-1:0]   estart_ff, estart_in;
   logic [31:0]     lacc_ff, lacc_in;
   logic [2:0]      lleft_ff, lleft_in;
   logic [PW-1:0]   cleft_ff, cleft_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [btsp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic            pend_v_ff, pend_v_in;
   btsp_pkg::rec_type pend_ff, pend_in;
   logic            out_v_ff, out_v_in;
   btsp_pkg::rec_type out_ff, out_in;
   logic            out_last_ff, out_last_in;

   // stack memory port signals
   logic            st_we, st_re;
   logic [AW-1:0]   st_waddr, st_raddr;
   btsp_pkg::frame_type st_wdata, st_rdata;

   // combinational helpers
   logic            acc, out_free, emit, emit_ok;
   btsp_pkg::rec_type emit_rec;
   logic [btsp_pkg::CNT_W-1:0] cnt_eff;
   logic [PW-1:0]   bpos_n;
   logic [31:0]     lacc_n;
   logic            hd, hd_indef, cons;
   logic [31:0]     hd_len;
   logic [6:0]      nb;
   logic [SP_W-1:0] sp_m1;
   logic [PW-1:0]   eoc_len;

   function automatic btsp_pkg::rec_type mk_rec(
      btsp_pkg::kind_type k, btsp_pkg::err_type e, logic [7:0] t,
      logic [PW-1:0] ho, logic [PW-1:0] co, logic [PW-1:0] cl,
      logic c, logic i, logic [SP_W-1:0] d);
      btsp_pkg::rec_type r;
      r.kind  = k;
      r.err   = e;
      r.tag   = t;
      r.hoff  = ho;
      r.coff  = co;
      r.clen  = cl;
      r.cons  = c;
      r.indef = i;
      r.depth = btsp_pkg::DEPTH_W'(d);
      return r;
   endfunction

   btsp_ram #(
      .WIDTH (btsp_pkg::STACK_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   assign out_free  = !out_v_ff || !rsp_stall;
   assign req_stall = (state_ff != btsp_pkg::S_IDLE) || pend_v_ff;
   assign acc       = req_valid && !req_stall;
   assign sp_m1     = sp_ff - SP_W'(1);
   assign bpos_n    = bpos_ff + PW'(1);
   assign lacc_n    = {lacc_ff[23:0], req_data_byte};
   assign nb        = req_data_byte[6:0];
   assign cons      = tag_ff[btsp_pkg::TAG_CONS_BIT];

   // decode the beat, walk the stack and produce records
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      bpos_in     = bpos_ff;
      fend_in     = fend_ff;
      tag_in      = tag_ff;
      estart_in   = estart_ff;
      lacc_in     = lacc_ff;
      lleft_in    = lleft_ff;
      cleft_in    = cleft_ff;
      sp_in       = sp_ff;
      cnt_in      = cnt_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_v_in    = out_v_ff && rsp_stall;
      st_we       = 1'b0;
      st_re       = 1'b0;
      st_waddr    = sp_ff[AW-1:0];
      st_raddr    = sp_m1[AW-1:0];
      st_wdata    = '{parent_end: fend_ff, content_start: bpos_n, indef: 1'b0};
      emit        = 1'b0;
      emit_rec    = '0;
      hd          = 1'b0;
      hd_indef    = 1'b0;
      hd_len      = '0;
      eoc_len     = '0;
      cnt_eff     = acc ? '0 : cnt_ff;
      emit_ok     = (cnt_eff >= btsp_pkg::CNT_W'(btsp_pkg::MAX_RESULTS)) || !pend_v_ff
                    || out_free;

      case (state_ff)
         btsp_pkg::S_IDLE: begin
            // hand over the final record of the previous beat
            if (pend_v_ff && out_free) begin
               out_v_in    = 1'b1;
               out_in      = pend_ff;
               out_last_in = 1'b1;
               pend_v_in   = 1'b0;
            end
            if (acc && req_op == btsp_pkg::OP_START) begin
               bpos_in   = '0;
               estart_in = '0;
               tag_in    = '0;
               lacc_in   = '0;
               lleft_in  = '0;
               cleft_in  = '0;
               sp_in     = '0;
               fend_in   = req_message_length;
               if (req_message_length == '0) begin
                  emit     = 1'b1;
                  emit_rec = mk_rec(btsp_pkg::KIND_DONE, btsp_pkg::ERR_NONE, '0, '0, '0, '0,
                                    1'b0, 1'b0, '0);
                  phase_in = btsp_pkg::PH_DONE;
               end else begin
                  phase_in = btsp_pkg::PH_TAG;
               end
            end else if (acc) begin
               case (phase_ff)
                  btsp_pkg::PH_TAG: begin
                     if ({1'b0, bpos_ff} + 32'd2 > {1'b0, fend_ff}) begin
                        emit     = 1'b1;
                        emit_rec = mk_rec(btsp_pkg::KIND_ERROR, btsp_pkg::ERR_BUFFER, '0, '0,
                                          '0, '0, 1'b0, 1'b0, sp_ff);
                        phase_in = btsp_pkg::PH_DONE;
                     end else begin
                        tag_in    = req_data_byte;
                        estart_in = bpos_ff;
                        bpos_in   = bpos_n;
                        phase_in  = btsp_pkg::PH_LEN;
                     end
                  end
                  btsp_pkg::PH_LEN: begin
                     bpos_in = bpos_n;
                     if (!req_data_byte[7]) begin
                        hd     = 1'b1;
                        hd_len = {24'd0, req_data_byte};
                     end else if (req_data_byte == btsp_pkg::LEN_INDEF) begin
                        if (cons) begin
                           hd       = 1'b1;
                           hd_indef = 1'b1;
                        end else begin
                           emit     = 1'b1;
                           emit_rec = mk_rec(btsp_pkg::KIND_ERROR, btsp_pkg::ERR_LENGTH, '0,
                                             '0, '0, '0, 1'b0, 1'b0, sp_ff);
                           phase_in = btsp_pkg::PH_DONE;
                        end
                     end else if (nb > btsp_pkg::LEN_MAX_NB) begin
                        emit     = 1'b1;
                        emit_rec = mk_rec(btsp_pkg::KIND_ERROR, btsp_pkg::ERR_LENGTH, '0, '0,
                                          '0, '0, 1'b0, 1'b0, sp_ff);
                        phase_in = btsp_pkg::PH_DONE;
                     end else if ({1'b0, bpos_n} + {25'd0, nb} > {1'b0, fend_ff}) begin
                        emit     = 1'b1;
                        emit_rec = mk_rec(btsp_pkg::KIND_ERROR, btsp_pkg::ERR_BUFFER, '0, '0,
                                          '0, '0, 1'b0, 1'b0, sp_ff);
                        phase_in = btsp_pkg::PH_DONE;
                     end else begin
                        lacc_in  = '0;
                        lleft_in = nb[2:0];
                        phase_in = btsp_pkg::PH_LENX;
                     end
                  end
                  btsp_pkg::PH_LENX: begin
                     bpos_in  = bpos_n;
                     lacc_in  = lacc_n;
                     lleft_in = lleft_ff - 3'd1;
                     if (lleft_ff == 3'd1) begin
                        hd     = 1'b1;
                        hd_len = lacc_n;
                     end
                  end
                  btsp_pkg::PH_SKIP: begin
                     bpos_in  = bpos_n;
                     cleft_in = cleft_ff - PW'(1);
                     if (cleft_ff == PW'(1)) begin
                        state_in = btsp_pkg::S_SETTLE;
                     end
                  end
                  default: begin
                  end
               endcase

               // complete a header: check, report open, then push, skip or close
               if (hd) begin
                  if (!hd_indef &&
                      ({2'b0, bpos_n} + {1'b0, hd_len} > {2'b0, fend_ff})) begin
                     emit     = 1'b1;
                     emit_rec = mk_rec(btsp_pkg::KIND_ERROR, btsp_pkg::ERR_BUFFER, '0, '0,
                                       '0, '0, 1'b0, 1'b0, sp_ff);
                     phase_in = btsp_pkg::PH_DONE;
                  end else if (cons && sp_ff >= SP_W'(STACK_DEPTH)) begin
                     emit     = 1'b1;
                     emit_rec = mk_rec(btsp_pkg::KIND_ERROR, btsp_pkg::ERR_DEPTH, '0, '0,
                                       '0, '0, 1'b0, 1'b0, sp_ff);
                     phase_in = btsp_pkg::PH_DONE;
                  end else begin
                     emit     = 1'b1;
                     emit_rec = mk_rec(btsp_pkg::KIND_OPEN, btsp_pkg::ERR_NONE, tag_ff,
                                       estart_ff, bpos_n, hd_len[PW-1:0], cons, hd_indef,
                                       sp_ff);
                     if (cons) begin
                        st_we          = 1'b1;
                        st_wdata.indef = hd_indef;
                        sp_in          = sp_ff + SP_W'(1);
                        if (!hd_indef) begin
                           fend_in = bpos_n + hd_len[PW-1:0];
                        end
                        state_in = btsp_pkg::S_SETTLE;
                     end else if (tag_ff == '0 && hd_len == '0) begin
                        state_in = btsp_pkg::S_EOC;
                     end else if (hd_len != '0) begin
                        cleft_in = hd_len[PW-1:0];
                        phase_in = btsp_pkg::PH_SKIP;
                     end else begin
                        state_in = btsp_pkg::S_SETTLE;
                     end
                  end
               end
            end
         end

         btsp_pkg::S_SETTLE: begin
            // wait for a tag, finish, or fetch the innermost frame
            if (bpos_ff < fend_ff) begin
               phase_in = btsp_pkg::PH_TAG;
               state_in = btsp_pkg::S_IDLE;
            end else if (sp_ff == '0) begin
               emit     = 1'b1;
               emit_rec = mk_rec(btsp_pkg::KIND_DONE, btsp_pkg::ERR_NONE, '0, '0, '0, '0,
                                 1'b0, 1'b0, sp_ff);
               if (emit_ok) begin
                  phase_in = btsp_pkg::PH_DONE;
                  state_in = btsp_pkg::S_IDLE;
               end
            end else begin
               st_re    = 1'b1;
               state_in = btsp_pkg::S_SRD;
            end
         end

         btsp_pkg::S_SRD: begin
            // pop a used-up frame, or fail on an unterminated indefinite one
            emit = 1'b1;
            if (st_rdata.indef) begin
               emit_rec = mk_rec(btsp_pkg::KIND_ERROR, btsp_pkg::ERR_BUFFER, '0, '0, '0, '0,
                                 1'b0, 1'b0, sp_ff);
               if (emit_ok) begin
                  phase_in = btsp_pkg::PH_DONE;
                  state_in = btsp_pkg::S_IDLE;
               end
            end else begin
               emit_rec = mk_rec(btsp_pkg::KIND_CLOSE, btsp_pkg::ERR_NONE, '0, '0,
                                 st_rdata.content_start, fend_ff - st_rdata.content_start,
                                 1'b1, 1'b0, sp_m1);
               if (emit_ok) begin
                  fend_in  = st_rdata.parent_end;
                  sp_in    = sp_m1;
                  state_in = btsp_pkg::S_SETTLE;
               end
            end
         end

         btsp_pkg::S_EOC: begin
            // end-of-contents finishes the parse at top level, else reads the innermost frame
            if (sp_ff == '0) begin
               emit     = 1'b1;
               emit_rec = mk_rec(btsp_pkg::KIND_DONE, btsp_pkg::ERR_NONE, '0, '0, '0, '0,
                                 1'b0, 1'b0, sp_ff);
               if (emit_ok) begin
                  phase_in = btsp_pkg::PH_DONE;
                  state_in = btsp_pkg::S_IDLE;
               end
            end else begin
               st_re    = 1'b1;
               state_in = btsp_pkg::S_ERD;
            end
         end

         btsp_pkg::S_ERD: begin
            // close the innermost frame on end-of-contents
            if (st_rdata.indef) begin
               eoc_len = bpos_ff - st_rdata.content_start - PW'(2);
            end else begin
               eoc_len = fend_ff - st_rdata.content_start;
            end
            emit     = 1'b1;
            emit_rec = mk_rec(btsp_pkg::KIND_CLOSE, btsp_pkg::ERR_NONE, '0, '0,
                              st_rdata.content_start, eoc_len, 1'b1, st_rdata.indef, sp_m1);
            if (emit_ok) begin
               fend_in = st_rdata.parent_end;
               sp_in   = sp_m1;
               if (!st_rdata.indef && bpos_ff < fend_ff) begin
                  cleft_in = fend_ff - bpos_ff;
                  phase_in = btsp_pkg::PH_SKIP;
                  state_in = btsp_pkg::S_IDLE;
               end else begin
                  state_in = btsp_pkg::S_SETTLE;
               end
            end
         end

         default: begin
            state_in = btsp_pkg::S_IDLE;
         end
      endcase

      // queue the record; push the previous one out, drop beyond the limit
      if (emit && emit_ok &&
          cnt_eff < btsp_pkg::CNT_W'(btsp_pkg::MAX_RESULTS)) begin
         cnt_in    = cnt_eff + btsp_pkg::CNT_W'(1);
         pend_in   = emit_rec;
         pend_v_in = 1'b1;
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_in      = pend_ff;
            out_last_in = 1'b0;
         end
      end else if (acc) begin
         cnt_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= btsp_pkg::S_IDLE;
         phase_ff  <= btsp_pkg::PH_IDLE;
         bpos_ff   <= '0;
         fend_ff   <= '0;
         tag_ff    <= '0;
         estart_ff <= '0;
         lacc_ff   <= '0;
         lleft_ff  <= '0;
         cleft_ff  <= '0;
         sp_ff     <= '0;
         cnt_ff    <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         bpos_ff   <= bpos_in;
         fend_ff   <= fend_in;
         tag_ff    <= tag_in;
         estart_ff <= estart_in;
         lacc_ff   <= lacc_in;
         lleft_ff  <= lleft_in;
         cleft_ff  <= cleft_in;
         sp_ff     <= sp_in;
         cnt_ff    <= cnt_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   // record payload registers
   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_error_code     = out_ff.err;
   assign rsp_tag            = out_ff.tag;
   assign rsp_header_offset  = out_ff.hoff;
   assign rsp_content_offset = out_ff.coff;
   assign rsp_content_length = out_ff.clen;
   assign rsp_constructed    = out_ff.cons;
   assign rsp_indefinite     = out_ff.indef;
   assign rsp_depth          = out_ff.depth;
   assign rsp_last           = out_last_ff;

endmodule

/* src/btsp_checker.sv */
// Port-level checker for the BER TLV stream parser, bound to the top level
`include "ber_tlv_stream_parser_defines.svh"

module btsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_op,
   input logic [30:0] req_message_length,
   input logic [7:0]  req_data_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [1:0]  rsp_error_code,
   input logic [7:0]  rsp_tag,
   input logic [30:0] rsp_header_offset,
   input logic [30:0] rsp_content_offset,
   input logic [30:0] rsp_content_length,
   input logic        rsp_constructed,
   input logic        rsp_indefinite,
   input logic [4:0]  rsp_depth,
   input logic        rsp_last
);

   // a stalled result beat holds
   `BTSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_content_length) && $stable(rsp_last), "result beat changed under stall")

   // an error code appears exactly on error records
   `BTSP_ASSERT(a_err_code, clock, reset, rsp_valid |-> ((rsp_kind == btsp_pkg::KIND_ERROR) == (rsp_error_code != btsp_pkg::ERR_NONE)), "error code does not match record kind")

   // finished and error records end the beat's records
   `BTSP_ASSERT(a_end_last, clock, reset, rsp_valid && (rsp_kind == btsp_pkg::KIND_DONE || rsp_kind == btsp_pkg::KIND_ERROR) |-> rsp_last, "final record not marked last")

   // indefinite open records carry no length
   `BTSP_ASSERT(a_indef_open, clock, reset, rsp_valid && rsp_kind == btsp_pkg::KIND_OPEN && rsp_indefinite |-> rsp_constructed && rsp_content_length == '0, "indefinite open record malformed")

endmodule

bind ber_tlv_stream_parser btsp_checker u_btsp_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for the BER TLV stream parser, with a byte-level predictor
module testbench;

   localparam int          CYCLE_LIMIT = 600000;
   localparam int          RANDOM_BEATS = 45;
   localparam int          TAIL_BEATS = 40;
   localparam int          FW = $clog2(btsp_pkg::STACK_DEPTH_DEF);
   localparam logic [31:0] POS_MASK = 32'h7FFF_FFFF;

   typedef logic [7:0] octets_type[$];

   typedef struct {
      logic        op;
      logic [30:0] msg_len;
      logic [7:0]  data;
   } beat_type;

   typedef struct {
      btsp_pkg::rec_type rec;
      logic              last;
   } parse_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_op = btsp_pkg::OP_START;
   logic [30:0] req_message_length = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_stall = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_error_code;
   logic [7:0]  rsp_tag;
   logic [30:0] rsp_header_offset;
   logic [30:0] rsp_content_offset;
   logic [30:0] rsp_content_length;
   logic        rsp_constructed;
   logic        rsp_indefinite;
   logic [4:0]  rsp_depth;
   logic        rsp_last;

   beat_type      pending_beats[$];
   parse_rec_type expected_records[$];
   bit            stimulus_ready = 0;
   int            beats_taken = 0;
   int            mismatches = 0;
   int            cycle_count = 0;
   int            send_idle = 0;
   int            recv_idle = 0;
   int            hold_off = 0;
   bit            hold_done = 0;
   bit            tail_part = 0;

   ber_tlv_stream_parser u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_message_length(req_message_length), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_error_code(rsp_error_code), .rsp_tag(rsp_tag),
      .rsp_header_offset(rsp_header_offset), .rsp_content_offset(rsp_content_offset),
      .rsp_content_length(rsp_content_length), .rsp_constructed(rsp_constructed),
      .rsp_indefinite(rsp_indefinite), .rsp_depth(rsp_depth), .rsp_last(rsp_last)
   );

   // ---------------------------------------------------------------- parser predictor
   logic [31:0] pos, fend, estart, skip_left, len_acc, len_left, sp;
   logic [7:0]  tag_q;
   btsp_pkg::phase_type phase = btsp_pkg::PH_IDLE;
   logic [31:0] frame_parent_end[btsp_pkg::STACK_DEPTH_DEF];
   logic [31:0] frame_content_start[btsp_pkg::STACK_DEPTH_DEF];
   logic        frame_indef[btsp_pkg::STACK_DEPTH_DEF];

   function automatic void add_rec(btsp_pkg::kind_type k, btsp_pkg::err_type e,
                                   logic [7:0] t, logic [31:0] h, logic [31:0] c,
                                   logic [31:0] l, logic cn, logic ind);
      parse_rec_type p;
      p.rec.kind = k;
      p.rec.err = e;
      p.rec.tag = t;
      p.rec.hoff = h[30:0];
      p.rec.coff = c[30:0];
      p.rec.clen = l[30:0];
      p.rec.cons = cn;
      p.rec.indef = ind;
      p.rec.depth = sp[4:0];
      p.last = 1'b0;
      expected_records.push_back(p);
   endfunction

   function automatic void abort_parse(btsp_pkg::err_type e);
      add_rec(btsp_pkg::KIND_ERROR, e, '0, '0, '0, '0, 1'b0, 1'b0);
      phase = btsp_pkg::PH_DONE;
   endfunction

   // Close every used-up frame, then wait for a tag or finish
   function automatic void close_spent_frames();
      logic [31:0] t;
      forever begin
         if (pos < fend) begin
            phase = btsp_pkg::PH_TAG;
            return;
         end
         if (sp == 0) begin
            add_rec(btsp_pkg::KIND_DONE, btsp_pkg::ERR_NONE, '0, '0, '0, '0, 1'b0, 1'b0);
            phase = btsp_pkg::PH_DONE;
            return;
         end
         t = sp - 1;
         if (frame_indef[t[FW-1:0]]) begin
            abort_parse(btsp_pkg::ERR_BUFFER);
            return;
         end
         sp = t;
         add_rec(btsp_pkg::KIND_CLOSE, btsp_pkg::ERR_NONE, '0, '0,
                 frame_content_start[t[FW-1:0]],
                 (fend - frame_content_start[t[FW-1:0]]) & POS_MASK, 1'b1, 1'b0);
         fend = frame_parent_end[t[FW-1:0]];
      end
   endfunction

   function automatic void end_of_contents();
      logic [31:0] t, l, old_end;
      logic        ind;
      if (sp == 0) begin
         add_rec(btsp_pkg::KIND_DONE, btsp_pkg::ERR_NONE, '0, '0, '0, '0, 1'b0, 1'b0);
         phase = btsp_pkg::PH_DONE;
         return;
      end
      t = sp - 1;
      old_end = fend;
      ind = frame_indef[t[FW-1:0]];
      if (ind) l = (pos - frame_content_start[t[FW-1:0]] - 2) & POS_MASK;
      else l = (old_end - frame_content_start[t[FW-1:0]]) & POS_MASK;
      fend = frame_parent_end[t[FW-1:0]];
      sp = t;
      add_rec(btsp_pkg::KIND_CLOSE, btsp_pkg::ERR_NONE, '0, '0,
              frame_content_start[t[FW-1:0]], l, 1'b1, ind);
      if (!ind && pos < old_end) begin
         skip_left = old_end - pos;
         phase = btsp_pkg::PH_SKIP;
         return;
      end
      close_spent_frames();
   endfunction

   function automatic void header_complete(logic ind);
      logic        cn;
      logic [31:0] l;
      cn = tag_q[btsp_pkg::TAG_CONS_BIT];
      l = ind ? 32'd0 : len_acc;
      if (!ind && ({32'd0, pos} + {32'd0, len_acc} > {32'd0, fend})) begin
         abort_parse(btsp_pkg::ERR_BUFFER);
         return;
      end
      if (cn && sp >= btsp_pkg::STACK_DEPTH_DEF) begin
         abort_parse(btsp_pkg::ERR_DEPTH);
         return;
      end
      add_rec(btsp_pkg::KIND_OPEN, btsp_pkg::ERR_NONE, tag_q, estart, pos, l, cn, ind);
      if (cn) begin
         frame_parent_end[sp[FW-1:0]] = fend;
         frame_content_start[sp[FW-1:0]] = pos;
         frame_indef[sp[FW-1:0]] = ind;
         sp = sp + 1;
         if (!ind) fend = pos + l;
         close_spent_frames();
      end else if (tag_q == 0 && l == 0) begin
         end_of_contents();
      end else if (l > 0) begin
         skip_left = l;
         phase = btsp_pkg::PH_SKIP;
      end else begin
         close_spent_frames();
      end
   endfunction

   function automatic void parse_step(beat_type bt);
      int          before_n;
      logic [31:0] b;
      before_n = expected_records.size();
      b = {24'd0, bt.data};
      if (bt.op == btsp_pkg::OP_START) begin
         pos = 0; estart = 0; skip_left = 0; len_acc = 0; len_left = 0; sp = 0; tag_q = 0;
         fend = {1'b0, bt.msg_len};
         close_spent_frames();
      end else begin
         case (phase)
            btsp_pkg::PH_TAG: begin
               if ({32'd0, pos} + 64'd2 > {32'd0, fend}) abort_parse(btsp_pkg::ERR_BUFFER);
               else begin
                  tag_q = bt.data;
                  estart = pos;
                  pos = pos + 1;
                  phase = btsp_pkg::PH_LEN;
               end
            end
            btsp_pkg::PH_LEN: begin
               pos = pos + 1;
               if (b < 32'h80) begin
                  len_acc = b;
                  header_complete(1'b0);
               end else if (bt.data == btsp_pkg::LEN_INDEF) begin
                  if (tag_q[btsp_pkg::TAG_CONS_BIT]) header_complete(1'b1);
                  else abort_parse(btsp_pkg::ERR_LENGTH);
               end else if (b - 32'h80 > {25'd0, btsp_pkg::LEN_MAX_NB}) begin
                  abort_parse(btsp_pkg::ERR_LENGTH);
               end else if ({32'd0, pos} + {32'd0, b - 32'h80} > {32'd0, fend}) begin
                  abort_parse(btsp_pkg::ERR_BUFFER);
               end else begin
                  len_acc = 0;
                  len_left = b - 32'h80;
                  phase = btsp_pkg::PH_LENX;
               end
            end
            btsp_pkg::PH_LENX: begin
               pos = pos + 1;
               len_acc = (len_acc << 8) | b;
               len_left = len_left - 1;
               if (len_left == 0) header_complete(1'b0);
            end
            btsp_pkg::PH_SKIP: begin
               pos = pos + 1;
               skip_left = (skip_left - 1) & POS_MASK;
               if (skip_left == 0) close_spent_frames();
            end
            default: ;
         endcase
      end
      if (expected_records.size() > before_n)
         expected_records[expected_records.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- encoding builders
   function automatic octets_type encode_length(int n, bit indef);
      octets_type r;
      int         nb;
      if (indef) begin
         r.push_back(btsp_pkg::LEN_INDEF);
         return r;
      end
      if (n < 128 && $urandom_range(0, 2) != 0) begin
         r.push_back(n[7:0]);
         return r;
      end
      nb = $urandom_range(1, 4);
      r.push_back(8'h80 + nb[7:0]);
      for (int i = nb - 1; i >= 0; i--) r.push_back(8'((n >> (8 * i)) & 255));
      return r;
   endfunction

   // Build one well-formed element with random content
   function automatic octets_type build_element(int lvl);
      octets_type body, hdr, kid;
      logic [7:0] t;
      bit         cn, ind;
      int         n;
      cn = (lvl < 5) && ($urandom_range(0, 2) != 0);
      t = 8'($urandom_range(1, 255));
      t[btsp_pkg::TAG_CONS_BIT] = cn;
      if (t == 0) t = 8'h01;
      ind = 0;
      if (cn) begin
         ind = 1'($urandom_range(0, 1));
         n = $urandom_range(0, 3);
         repeat (n) begin
            kid = build_element(lvl + 1);
            body = {body, kid};
         end
         if (ind) body = {body, 8'h00, 8'h00};
      end else begin
         n = $urandom_range(0, 5);
         repeat (n) body.push_back(8'($urandom_range(0, 255)));
      end
      hdr = encode_length(body.size(), ind);
      return {t, hdr, body};
   endfunction

   function automatic void add_start(logic [30:0] l);
      beat_type bt;
      bt.op = btsp_pkg::OP_START;
      bt.msg_len = l;
      bt.data = 8'($urandom_range(0, 255));
      pending_beats.push_back(bt);
   endfunction

   function automatic void add_octets(octets_type q);
      beat_type bt;
      foreach (q[i]) begin
         bt.op = btsp_pkg::OP_BYTE;
         bt.msg_len = {15'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535))};
         bt.data = q[i];
         pending_beats.push_back(bt);
      end
   endfunction

   function automatic void add_message(octets_type q, logic [30:0] l);
      add_start(l);
      add_octets(q);
   endfunction

   // ---------------------------------------------------------------- stimulus
   initial begin
      octets_type q, e;
      int         base, pick, n;

      // Directed: empty message, tiny frames, bad lengths, deep nesting, end markers
      add_start(31'd0);
      add_message('{8'h04}, 31'd1);
      add_message('{8'h04, 8'h80}, 31'd2);
      add_message('{8'h04, 8'h85}, 31'd6);
      add_message('{8'h30, 8'h80}, 31'd2);
      add_message('{8'h00, 8'h00, 8'hFF}, 31'd3);
      add_message('{8'h30, 8'h04, 8'h00, 8'h00, 8'hAA, 8'hBB}, 31'd6);
      add_message('{8'hFF, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'h7F}, 31'd7);
      add_message('{8'h02, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 31'h7FFF_FFFF);
      q = {};
      repeat (btsp_pkg::STACK_DEPTH_DEF + 1) q = {q, 8'h30, 8'h80};
      add_message(q, 31'd100);
      q = {};
      repeat (btsp_pkg::STACK_DEPTH_DEF) q = {q, 8'h30, 8'h80};
      repeat (btsp_pkg::STACK_DEPTH_DEF) q = {q, 8'h00, 8'h00};
      add_message(q, 31'(q.size()));
      q = {};
      for (int i = btsp_pkg::STACK_DEPTH_DEF; i > 0; i--) q = {q, 8'h30, 8'((i - 1) * 2)};
      add_message(q, 31'(q.size()));
      add_octets('{8'h12, 8'h34});

      // Random: mostly well-formed messages, some damaged, some noise
      base = pending_beats.size();
      while (pending_beats.size() - base < RANDOM_BEATS) begin
         pick = $urandom_range(0, 19);
         q = {};
         n = $urandom_range(1, 3);
         repeat (n) begin
            e = build_element(0);
            q = {q, e};
         end
         if (pick < 13) begin
            add_message(q, 31'(q.size()));
         end else if (pick < 15) begin
            add_message(q, 31'(q.size() + $urandom_range(0, 3) - 2));
         end else if (pick < 16) begin
            add_start({15'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535))});
            q = {};
            repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
            add_octets(q);
         end else if (pick < 18) begin
            q = q[0:$urandom_range(0, q.size() - 1)];
            add_message(q, 31'($urandom_range(q.size(), q.size() + 20)));
         end else begin
            q = {};
            repeat ($urandom_range(2, 8)) q.push_back(8'($urandom_range(0, 255)));
            add_message(q, 31'($urandom_range(0, 12)));
         end
      end
      stimulus_ready = 1;
   end

   // ---------------------------------------------------------------- clock and reset
   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- request driver
   always @(posedge clock) begin
      bit next_valid;
      next_valid = req_valid;
      if (!reset && stimulus_ready) begin
         if (req_valid && !req_stall) begin
            parse_step(pending_beats.pop_front());
            beats_taken++;
            next_valid = 1'b0;
         end
         if (pending_beats.size() <= TAIL_BEATS) tail_part = 1;
         if (!next_valid) begin
            if (send_idle > 0) begin
               send_idle--;
            end else if (!tail_part && $urandom_range(0, 6) == 0) begin
               send_idle = $urandom_range(0, 10);
            end else if (pending_beats.size() > 0) begin
               next_valid = 1'b1;
               req_op <= pending_beats[0].op;
               req_message_length <= pending_beats[0].msg_len;
               req_data_byte <= pending_beats[0].data;
            end
         end
      end
      req_valid <= next_valid;
   end

   // ---------------------------------------------------------------- response stall
   always @(posedge clock) begin
      bit stall_next;
      stall_next = 1'b0;
      if (!hold_done && beats_taken >= 80) begin
         hold_done = 1;
         hold_off = 400;
      end
      if (hold_off > 0) begin
         hold_off--;
         stall_next = 1'b1;
      end else if (recv_idle > 0) begin
         recv_idle--;
         stall_next = 1'b1;
      end else if (!tail_part && $urandom_range(0, 5) == 0) begin
         recv_idle = $urandom_range(0, 10);
         stall_next = 1'b1;
      end
      rsp_stall <= stall_next;
   end

   // ---------------------------------------------------------------- record monitor
   always @(posedge clock) begin
      parse_rec_type want;
      bit            bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_records.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected record kind=%0d err=%0d depth=%0d",
                        rsp_kind, rsp_error_code, rsp_depth);
         end else begin
            want = expected_records.pop_front();
            bad = (rsp_kind != want.rec.kind) || (rsp_error_code != want.rec.err) ||
                  (rsp_tag != want.rec.tag) || (rsp_header_offset != want.rec.hoff) ||
                  (rsp_content_offset != want.rec.coff) ||
                  (rsp_content_length != want.rec.clen) ||
                  (rsp_constructed != want.rec.cons) || (rsp_indefinite != want.rec.indef) ||
                  (rsp_depth != want.rec.depth) || (rsp_last != want.last);
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("record mismatch: expected k=%0d e=%0d t=%h h=%0d c=%0d l=%0d",
                           want.rec.kind, want.rec.err, want.rec.tag, want.rec.hoff,
                           want.rec.coff, want.rec.clen);
                  $display("   cons=%0d ind=%0d d=%0d last=%0d", want.rec.cons,
                           want.rec.indef, want.rec.depth, want.last);
                  $display("  actual k=%0d e=%0d t=%h h=%0d c=%0d l=%0d", rsp_kind,
                           rsp_error_code, rsp_tag, rsp_header_offset, rsp_content_offset,
                           rsp_content_length);
                  $display("   cons=%0d ind=%0d d=%0d last=%0d", rsp_constructed,
                           rsp_indefinite, rsp_depth, rsp_last);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ber_tlv_stream_parser verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- end of run
   initial begin
      wait (stimulus_ready);
      wait (pending_beats.size() == 0 && !req_valid && expected_records.size() == 0);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && expected_records.size() == 0) begin
         $display("ber_tlv_stream_parser verification clean");
      end else begin
         $display("ber_tlv_stream_parser verification failed");
      end
      $finish;
   end

endmodule
